// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the RTL, included by bki_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BKI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define BKI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/bki_pkg.sv =====
// Shared constants, codes and control structs for the knot insertion block.
`timescale 1ns / 1ps
`default_nettype none

package bki_pkg;

  localparam int MAX_POLES  = 64;
  localparam int MAX_DEGREE = 25;
  localparam int KNOT_DEPTH = 128;
  localparam int KNOT_CAP   = KNOT_DEPTH - 1;

  localparam int KIDX_W = $clog2(KNOT_DEPTH);
  localparam int PIDX_W = $clog2(MAX_POLES);
  localparam int PCNT_W = $clog2(MAX_POLES + 1);
  localparam int KCNT_W = KIDX_W;
  localparam int IDX_W  = (KIDX_W > PCNT_W) ? KIDX_W : PCNT_W;
  localparam int SPAN_W = IDX_W + 1;

  localparam int OP_W      = 3;
  localparam int ST_W      = 3;
  localparam int ENTRY_W   = 7;
  localparam int TGT_W     = 5;
  localparam int DEG_W     = 5;
  localparam int BUDGET_W  = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int HELD_W    = 7;

  localparam int KNOT_W  = 32;
  localparam int COORD_W = 48;
  localparam int AXES    = 4;
  localparam int POLE_W  = AXES * COORD_W;

  // blend arithmetic: difference split into a signed high and unsigned low part
  localparam int SPLIT  = 24;
  localparam int DIFF_W = COORD_W + 1;
  localparam int HI_W   = DIFF_W - SPLIT;
  localparam int LOP_W  = SPLIT + KNOT_W;
  localparam int HIP_W  = HI_W + KNOT_W + 1;
  localparam int SUM_W  = DIFF_W + KNOT_W + 1;
  localparam int QSHIFT = 31;

  localparam logic [KNOT_W-1:0]   Q_ONE      = KNOT_W'(1) << QSHIFT;
  localparam logic [SUM_W-1:0]    ROUND_HALF = SUM_W'(1) << (QSHIFT - 1);
  localparam logic [DEG_W-1:0]    DEGREE_RST = DEG_W'(3);
  localparam logic [BUDGET_W-1:0] BUDGET_RST = BUDGET_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_APP_KNOT = 3'd1,
    OP_APP_POLE = 3'd2,
    OP_INSERT   = 3'd3,
    OP_RD_KNOT  = 3'd4,
    OP_RD_POLE  = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_DOMAIN = 3'd1,
    ST_BUDGET = 3'd2,
    ST_SPAN   = 3'd3,
    ST_ZERO   = 3'd4,
    ST_RANGE  = 3'd5
  } st_t;

  typedef enum logic [1:0] {SEL_NONE, SEL_KNOT, SEL_POLE} sel_t;
  typedef enum logic {KW_ITEM, KW_COPY} kw_src_t;
  typedef enum logic [1:0] {PW_ITEM, PW_COPY, PW_BLEND} pw_src_t;

  typedef struct packed {
    logic              item_load;
    logic              kr_en;
    logic [KIDX_W-1:0] kra;
    logic [KIDX_W-1:0] krb;
    logic              kw_en;
    logic [KIDX_W-1:0] kwa;
    kw_src_t           kw_src;
    logic              pr_en;
    logic [PIDX_W-1:0] pra;
    logic [PIDX_W-1:0] prb;
    logic              pw_en;
    logic [PIDX_W-1:0] pwa;
    pw_src_t           pw_src;
    logic              alpha_start;
    logic              mul_en;
    logic              sum_en;
  } dp_cmd_t;

  typedef struct packed {
    logic t_ok;
    logic ka_eq_t;
    logic ka_gt_t;
    logic kb_le_ka;
    logic alpha_valid;
  } dp_stat_t;

  typedef struct packed {
    logic valid;
    st_t  status;
    sel_t sel;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bspline_knot_insertion_top.sv =====
// Top level of the rational B-spline knot insertion block.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Width  Contents
// s_*      in   240    request: opcode, entry_index, knot_value, target_multiplicity, x/y/z/w
// m_*      out  248    result: status, out_knot, out_x/y/z/w, poles_held, knots_held
// cfg_*    in   1+1+7  register writes: 0 curve_degree, 1 pole_budget
//
// Clear, append and read requests pass through dispatch and finish states; the result
// register loads when the finish state sees the output free. Insert: scans stored knots
// for the multiplicity count, then per Boehm step scans knots for the span, checks for
// zero intervals, moves tail poles and knots, and blends poles, dividing if not clamped.
// Knot and pole memories have one write and two read ports; the divider sets the pace.
// Reset (rst, synchronous) clears counts and handshakes, presets config; memories keep data.
// A request is taken only in the idle state; a held result does not block that accept.

module bspline_knot_insertion_top
  import bki_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // opcode[2:0] entry_index[9:3] knot_value[41:10] target_multiplicity[46:42]
  // in_x[94:47] in_y[142:95] in_z[190:143] in_w[238:191] pad[239]
  input  wire logic [239:0]         s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // status[2:0] out_knot[34:3] out_x[82:35] out_y[130:83] out_z[178:131]
  // out_w[226:179] poles_held[233:227] knots_held[240:234] pad[247:241]
  output logic [247:0]              m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // unpacked request fields
  logic [OP_W-1:0]    opcode;
  logic [ENTRY_W-1:0] entry_index;
  logic [KNOT_W-1:0]  knot_value;
  logic [TGT_W-1:0]   target_multiplicity;
  logic [POLE_W-1:0]  in_pole;

  assign opcode              = s_tdata[2:0];
  assign entry_index         = s_tdata[9:3];
  assign knot_value          = s_tdata[41:10];
  assign target_multiplicity = s_tdata[46:42];
  assign in_pole             = s_tdata[238:47];  // x lowest, w highest

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  res_t               res;
  logic [KNOT_W-1:0]  rd_knot;
  logic [POLE_W-1:0]  rd_pole;
  logic [HELD_W-1:0]  poles_held, knots_held;
  logic               out_free;

  // result register frees the controller to take the next request
  assign out_free = !m_tvalid || m_tready;

  bki_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .opcode      (opcode),
    .entry_index (entry_index),
    .target      (target_multiplicity),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_free    (out_free),
    .res         (res),
    .poles_held  (poles_held),
    .knots_held  (knots_held)
  );

  bki_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .knot_value (knot_value),
    .in_pole    (in_pole),
    .stat       (stat),
    .rd_knot    (rd_knot),
    .rd_pole    (rd_pole)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload: read data only for a good read, zeros otherwise
  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata[2:0]     <= res.status;
      m_tdata[34:3]    <= (res.sel == SEL_KNOT) ? rd_knot : '0;
      m_tdata[226:35]  <= (res.sel == SEL_POLE) ? rd_pole : '0;
      m_tdata[233:227] <= poles_held;
      m_tdata[240:234] <= knots_held;
      m_tdata[247:241] <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bki_div.sv =====
// Restoring divider for the rounded Q1.31 blend factor, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module bki_div
  import bki_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [KNOT_W-1:0] num,
  input  wire logic [KNOT_W-1:0] den,
  output logic                   done,
  output logic [KNOT_W-1:0]      quo
);

  localparam int DVD_W = 2 * KNOT_W - 1;
  localparam int CNT_W = $clog2(KNOT_W + 1);

  logic [DVD_W-1:0]  dividend;
  logic [KNOT_W-1:0] rem;
  logic [KNOT_W-1:0] low;
  logic [KNOT_W-1:0] dreg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [KNOT_W:0]   trial;
  logic              qbit;

  // num * 2^31 + den / 2, so the quotient comes out rounded half up
  assign dividend = {num, {(KNOT_W - 1){1'b0}}} + DVD_W'(den >> 1);
  assign trial    = {rem, low[KNOT_W-1]};
  assign qbit     = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= KNOT_W'(dividend[DVD_W-1:KNOT_W]);
        low  <= dividend[KNOT_W-1:0];
        dreg <= den;
        cnt  <= CNT_W'(KNOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= qbit ? KNOT_W'(trial - {1'b0, dreg}) : trial[KNOT_W-1:0];
        low  <= {low[KNOT_W-2:0], 1'b0};
        quo  <= {quo[KNOT_W-2:0], qbit};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bki_datapath.sv =====
// Knot and pole memories, item latch, blend factor and four-lane blend arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module bki_datapath
  import bki_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  input  wire logic [KNOT_W-1:0]   knot_value,
  input  wire logic [POLE_W-1:0]   in_pole,
  output dp_stat_t                 stat,
  output logic [KNOT_W-1:0]        rd_knot,
  output logic [POLE_W-1:0]        rd_pole
);

  logic [KNOT_W-1:0] kmem [KNOT_DEPTH];
  logic [POLE_W-1:0] pmem [MAX_POLES];

  logic [KNOT_W-1:0] t_r;
  logic [POLE_W-1:0] item_pole;
  logic [KNOT_W-1:0] ka, kb;
  logic [POLE_W-1:0] pa, pb;

  logic [KNOT_W-1:0] alpha;
  logic              alpha_valid;
  logic [KNOT_W-1:0] num, den;
  logic              div_start, div_done;
  logic [KNOT_W-1:0] div_quo;

  logic signed [DIFF_W-1:0] diff [AXES];
  logic        [LOP_W-1:0]  plo  [AXES];
  logic signed [HIP_W-1:0]  phi  [AXES];
  logic signed [SUM_W-1:0]  sum  [AXES];
  logic signed [SUM_W-1:0]  shr  [AXES];
  logic [POLE_W-1:0]        blend_res;
  logic [KNOT_W-1:0]        kw_data;
  logic [POLE_W-1:0]        pw_data;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      t_r       <= knot_value;
      item_pole <= in_pole;
    end
  end

  // knot memory: one write, two registered reads
  assign kw_data = (cmd.kw_src == KW_ITEM) ? t_r : ka;

  always_ff @(posedge clk) begin
    if (cmd.kw_en) kmem[cmd.kwa] <= kw_data;
    if (cmd.kr_en) begin
      ka <= kmem[cmd.kra];
      kb <= kmem[cmd.krb];
    end
  end

  always_comb begin
    case (cmd.pw_src)
      PW_ITEM:  pw_data = item_pole;
      PW_COPY:  pw_data = pa;
      PW_BLEND: pw_data = blend_res;
      default:  pw_data = item_pole;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pw_en) pmem[cmd.pwa] <= pw_data;
    if (cmd.pr_en) begin
      pa <= pmem[cmd.pra];
      pb <= pmem[cmd.prb];
    end
  end

  // blend factor: clamp to 0 or one, else divide
  assign num       = t_r - ka;
  assign den       = kb - ka;
  assign div_start = cmd.alpha_start && (t_r > ka) && (num < den);

  bki_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_valid <= 1'b0;
    end else if (cmd.alpha_start) begin
      if (t_r <= ka) begin
        alpha       <= '0;
        alpha_valid <= 1'b1;
      end else if (num >= den) begin
        alpha       <= Q_ONE;
        alpha_valid <= 1'b1;
      end else begin
        alpha_valid <= 1'b0;
      end
    end else if (div_done) begin
      alpha       <= div_quo;
      alpha_valid <= 1'b1;
    end
  end

  // P[i-1] + floor(((P[i] - P[i-1]) * alpha + 2^30) / 2^31), per lane
  always_ff @(posedge clk) begin
    for (int c = 0; c < AXES; c++) begin
      if (cmd.alpha_start) begin
        diff[c] <= $signed({pb[c*COORD_W + COORD_W - 1], pb[c*COORD_W +: COORD_W]})
                 - $signed({pa[c*COORD_W + COORD_W - 1], pa[c*COORD_W +: COORD_W]});
      end
      if (cmd.mul_en) begin
        plo[c] <= diff[c][SPLIT-1:0] * alpha;
        phi[c] <= $signed(diff[c][DIFF_W-1:SPLIT]) * $signed({1'b0, alpha});
      end
      if (cmd.sum_en) begin
        sum[c] <= (SUM_W'(phi[c]) <<< SPLIT) + SUM_W'(plo[c]) + ROUND_HALF;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < AXES; c++) begin
      shr[c] = sum[c] >>> QSHIFT;
      blend_res[c*COORD_W +: COORD_W] = pa[c*COORD_W +: COORD_W] + shr[c][COORD_W-1:0];
    end
  end

  assign stat.t_ok        = (t_r != '0) && (t_r < Q_ONE);
  assign stat.ka_eq_t     = (ka == t_r);
  assign stat.ka_gt_t     = (ka > t_r);
  assign stat.kb_le_ka    = (kb <= ka);
  assign stat.alpha_valid = alpha_valid;

  assign rd_knot = ka;
  assign rd_pole = pa;

endmodule

`default_nettype wire

// ===== rtl/bki_ctrl.sv =====
// Sequencer: decodes requests, walks the insertion steps and holds counts and config.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bki_ctrl
  import bki_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      opcode,
  input  wire logic [ENTRY_W-1:0]   entry_index,
  input  wire logic [TGT_W-1:0]     target,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output dp_cmd_t                   cmd,
  input  wire dp_stat_t             stat,
  input  wire logic                 out_free,
  output res_t                      res,
  output logic [HELD_W-1:0]         poles_held,
  output logic [HELD_W-1:0]         knots_held
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_CNT_RD, S_CNT_CMP, S_STEP, S_FND_RD, S_FND_CMP, S_SPAN,
    S_ZC_RD, S_ZC_CMP, S_TS_RD, S_TS_WR, S_BL_RD, S_BL_PREP, S_BL_DIV, S_BL_MUL,
    S_BL_SUM, S_BL_WR, S_KS_RD, S_KS_WR, S_FIN
  } state_t;

  state_t               state;
  op_t                  op_r;
  logic [ENTRY_W-1:0]   idx_r;
  logic [TGT_W-1:0]     tgt_r;
  logic [DEG_W-1:0]     degree;
  logic [BUDGET_W-1:0]  budget;
  logic [KCNT_W-1:0]    kt;
  logic [PCNT_W-1:0]    pt;
  logic [IDX_W-1:0]     cnt, i, j, k, lo, hi;
  st_t                  st_r;
  sel_t                 sel_r;

  logic [IDX_W-1:0]  p_x, ip, im1, jm1, k1;
  logic [SPAN_W-1:0] p_s, kk_s, hi_s, top_s, lo_s;
  logic              span_bad, budget_bad, domain_ok;

  assign p_x = IDX_W'(degree);
  assign ip  = i + p_x;
  assign im1 = i - 1'b1;
  assign jm1 = j - 1'b1;
  assign k1  = k + 1'b1;

  // span checks, k holds the first knot above t here
  assign p_s   = SPAN_W'(degree);
  assign kk_s  = SPAN_W'(k) - 1'b1;
  assign hi_s  = kk_s - SPAN_W'(cnt);
  assign top_s = hi_s + p_s;
  assign lo_s  = kk_s - p_s + 1'b1;
  assign span_bad = (k == '0) || (kk_s < p_s) || (kk_s < SPAN_W'(cnt))
                 || (hi_s >= SPAN_W'(pt)) || (top_s >= SPAN_W'(kt));

  assign budget_bad = (BUDGET_W'(pt) >= budget) || (pt >= PCNT_W'(MAX_POLES))
                   || (kt >= KCNT_W'(KNOT_CAP));
  assign domain_ok  = stat.t_ok && (tgt_r <= degree) && (degree <= DEG_W'(MAX_DEGREE));

  assign in_ready   = (state == S_IDLE);
  assign poles_held = HELD_W'(pt);
  assign knots_held = HELD_W'(kt);

  always_comb begin
    cmd        = '0;
    cmd.kra    = KIDX_W'(i);
    cmd.krb    = KIDX_W'(ip);
    cmd.pra    = PIDX_W'(im1);
    cmd.prb    = PIDX_W'(i);
    cmd.kwa    = KIDX_W'(j);
    cmd.pwa    = PIDX_W'(j);
    cmd.kw_src = KW_COPY;
    cmd.pw_src = PW_COPY;
    res.valid  = 1'b0;
    res.status = st_r;
    res.sel    = sel_r;
    case (state)
      S_IDLE: cmd.item_load = in_valid;
      S_DISPATCH: begin
        case (op_r)
          OP_APP_KNOT: begin
            cmd.kw_en  = (kt < KCNT_W'(KNOT_CAP));
            cmd.kwa    = KIDX_W'(kt);
            cmd.kw_src = KW_ITEM;
          end
          OP_APP_POLE: begin
            cmd.pw_en  = (pt < PCNT_W'(MAX_POLES));
            cmd.pwa    = PIDX_W'(pt);
            cmd.pw_src = PW_ITEM;
          end
          OP_RD_KNOT: begin
            cmd.kr_en = 1'b1;
            cmd.kra   = KIDX_W'(idx_r);
          end
          OP_RD_POLE: begin
            cmd.pr_en = 1'b1;
            cmd.pra   = PIDX_W'(idx_r);
          end
          default: ;
        endcase
      end
      S_CNT_RD, S_FND_RD: cmd.kr_en = (i < IDX_W'(kt));
      S_ZC_RD:  cmd.kr_en = (i <= hi);
      S_TS_RD: begin
        cmd.pr_en = (j > hi);
        cmd.pra   = PIDX_W'(jm1);
      end
      S_TS_WR:  cmd.pw_en = 1'b1;
      S_BL_RD: begin
        cmd.kr_en = 1'b1;
        cmd.pr_en = 1'b1;
      end
      S_BL_PREP: cmd.alpha_start = 1'b1;
      S_BL_MUL:  cmd.mul_en = 1'b1;
      S_BL_SUM:  cmd.sum_en = 1'b1;
      S_BL_WR: begin
        cmd.pw_en  = 1'b1;
        cmd.pwa    = PIDX_W'(i);
        cmd.pw_src = PW_BLEND;
      end
      S_KS_RD: begin
        if (j > k1) begin
          cmd.kr_en = 1'b1;
          cmd.kra   = KIDX_W'(jm1);
        end else begin
          cmd.kw_en  = 1'b1;
          cmd.kwa    = KIDX_W'(k1);
          cmd.kw_src = KW_ITEM;
        end
      end
      S_KS_WR:  cmd.kw_en = 1'b1;
      S_FIN:    res.valid = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kt     <= '0;
      pt     <= '0;
      degree <= DEGREE_RST;
      budget <= BUDGET_RST;
      st_r   <= ST_OK;
      sel_r  <= SEL_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEGREE: degree <= cfg_data[DEG_W-1:0];
          REG_BUDGET: budget <= cfg_data[BUDGET_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op_t'(opcode);
            idx_r <= entry_index;
            tgt_r <= target;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          st_r  <= ST_OK;
          sel_r <= SEL_NONE;
          state <= S_FIN;
          case (op_r)
            OP_CLEAR: begin
              kt <= '0;
              pt <= '0;
            end
            OP_APP_KNOT: begin
              if (kt >= KCNT_W'(KNOT_CAP)) st_r <= ST_RANGE;
              else kt <= kt + 1'b1;
            end
            OP_APP_POLE: begin
              if (pt >= PCNT_W'(MAX_POLES)) st_r <= ST_RANGE;
              else pt <= pt + 1'b1;
            end
            OP_INSERT: begin
              if (!domain_ok) begin
                st_r <= ST_DOMAIN;
              end else begin
                cnt   <= '0;
                i     <= '0;
                state <= S_CNT_RD;
              end
            end
            OP_RD_KNOT: begin
              if (IDX_W'(idx_r) >= IDX_W'(kt)) st_r <= ST_RANGE;
              else sel_r <= SEL_KNOT;
            end
            OP_RD_POLE: begin
              if (IDX_W'(idx_r) >= IDX_W'(pt)) st_r <= ST_RANGE;
              else sel_r <= SEL_POLE;
            end
            default: ;
          endcase
        end
        S_CNT_RD:  state <= (i >= IDX_W'(kt)) ? S_STEP : S_CNT_CMP;
        S_CNT_CMP: begin
          if (stat.ka_eq_t) cnt <= cnt + 1'b1;
          i     <= i + 1'b1;
          state <= S_CNT_RD;
        end
        S_STEP: begin
          if (cnt >= IDX_W'(tgt_r)) begin
            state <= S_FIN;
          end else if (budget_bad) begin
            st_r  <= ST_BUDGET;
            state <= S_FIN;
          end else begin
            i     <= '0;
            state <= S_FND_RD;
          end
        end
        S_FND_RD: begin
          if (i >= IDX_W'(kt)) begin
            k     <= IDX_W'(kt);
            state <= S_SPAN;
          end else begin
            state <= S_FND_CMP;
          end
        end
        S_FND_CMP: begin
          if (stat.ka_gt_t) begin
            k     <= i;
            state <= S_SPAN;
          end else begin
            i     <= i + 1'b1;
            state <= S_FND_RD;
          end
        end
        S_SPAN: begin
          if (span_bad) begin
            st_r  <= ST_SPAN;
            state <= S_FIN;
          end else begin
            k     <= IDX_W'(kk_s);
            lo    <= IDX_W'(lo_s);
            hi    <= IDX_W'(hi_s);
            i     <= IDX_W'(lo_s);
            state <= S_ZC_RD;
          end
        end
        S_ZC_RD: begin
          if (i > hi) begin
            j     <= IDX_W'(pt);
            state <= S_TS_RD;
          end else begin
            state <= S_ZC_CMP;
          end
        end
        S_ZC_CMP: begin
          if (stat.kb_le_ka) begin
            st_r  <= ST_ZERO;
            state <= S_FIN;
          end else begin
            i     <= i + 1'b1;
            state <= S_ZC_RD;
          end
        end
        S_TS_RD: begin
          if (j <= hi) begin
            i     <= hi;
            state <= S_BL_RD;
          end else begin
            state <= S_TS_WR;
          end
        end
        S_TS_WR: begin
          j     <= jm1;
          state <= S_TS_RD;
        end
        S_BL_RD:   state <= S_BL_PREP;
        S_BL_PREP: state <= S_BL_DIV;
        S_BL_DIV:  if (stat.alpha_valid) state <= S_BL_MUL;
        S_BL_MUL:  state <= S_BL_SUM;
        S_BL_SUM:  state <= S_BL_WR;
        S_BL_WR: begin
          if (i == lo) begin
            j     <= IDX_W'(kt);
            state <= S_KS_RD;
          end else begin
            i     <= im1;
            state <= S_BL_RD;
          end
        end
        S_KS_RD: begin
          if (j > k1) begin
            state <= S_KS_WR;
          end else begin
            kt    <= kt + 1'b1;
            pt    <= pt + 1'b1;
            cnt   <= cnt + 1'b1;
            state <= S_STEP;
          end
        end
        S_KS_WR: begin
          j     <= jm1;
          state <= S_KS_RD;
        end
        S_FIN: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `BKI_ASSERT(a_pole_cap, clk, rst, pt <= PCNT_W'(MAX_POLES), "pole count past capacity")
  `BKI_ASSERT(a_knot_cap, clk, rst, kt <= KCNT_W'(KNOT_CAP), "knot count past capacity")
  `BKI_ASSERT_IMP(a_fin_free, clk, rst, res.valid, out_free, "result issued over a full output")
  `BKI_ASSERT_IMP(a_blend_idx, clk, rst, state == S_BL_WR, (i >= lo) && (i <= hi), "blend index outside span")

endmodule

`default_nettype wire
